>>> design/http_request_router_assert.svh
// Assertion macros for the request router.
`ifndef HTTP_REQUEST_ROUTER_ASSERT_SVH
`define HTTP_REQUEST_ROUTER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define HRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hrr assertion failed");

// Checked at every edge, reset included.
`define HRR_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hrr assertion failed");

`else

`define HRR_ASSERT(lbl, clk, rst_n, prop)
`define HRR_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

>>> design/hrr_pkg.sv
`timescale 1ns / 1ps

package hrr_pkg;

    localparam logic [1:0] ROUTE_ROOT     = 2'd0;
    localparam logic [1:0] ROUTE_STATS    = 2'd1;
    localparam logic [1:0] ROUTE_EVENTS   = 2'd2;
    localparam logic [1:0] ROUTE_NOTFOUND = 2'd3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0] STATS_LEN  = 4'd10;
    localparam logic [3:0] EVENTS_LEN = 4'd7;
    localparam logic [3:0] HNAME_LEN  = 4'd11;
    localparam logic [3:0] HVAL_LEN   = 4'd10;
    localparam logic [3:0] COUNT_MAX  = 4'd15;

    // bit positions in the path candidate mask
    localparam int HOPE_ROOT   = 0;
    localparam int HOPE_STATS  = 1;
    localparam int HOPE_EVENTS = 2;

    typedef enum logic [2:0] {
        PH_METHOD = 3'b001,
        PH_PATH   = 3'b010,
        PH_HDR    = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        HP_NAME  = 3'b001,
        HP_VALUE = 3'b010,
        HP_DONE  = 3'b100
    } hdr_phase_t;

    typedef struct packed {
        logic       step;
        logic       last;
        logic [7:0] data;
    } hrr_word_t;

    typedef struct packed {
        logic [1:0] route;
        logic       persist;
    } hrr_result_t;

    function automatic logic [7:0] stats_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "/";
            4'd1:    c = "a";
            4'd2:    c = "p";
            4'd3:    c = "i";
            4'd4:    c = "/";
            4'd5:    c = "s";
            4'd6:    c = "t";
            4'd7:    c = "a";
            4'd8:    c = "t";
            4'd9:    c = "s";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] events_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "/";
            4'd1:    c = "e";
            4'd2:    c = "v";
            4'd3:    c = "e";
            4'd4:    c = "n";
            4'd5:    c = "t";
            4'd6:    c = "s";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hname_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "n";
            4'd4:    c = "e";
            4'd5:    c = "c";
            4'd6:    c = "t";
            4'd7:    c = "i";
            4'd8:    c = "o";
            4'd9:    c = "n";
            4'd10:   c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hval_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "k";
            4'd1:    c = "e";
            4'd2:    c = "e";
            4'd3:    c = "p";
            4'd4:    c = "-";
            4'd5:    c = "a";
            4'd6:    c = "l";
            4'd7:    c = "i";
            4'd8:    c = "v";
            4'd9:    c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> design/hrr_parse.sv
`timescale 1ns / 1ps
`include "http_request_router_assert.svh"

module hrr_parse
    import hrr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hrr_word_t   word,
    output hrr_result_t result
);

    phase_t     phase_reg, phase_next;
    logic [3:0] path_count_reg, path_count_next;
    logic [2:0] path_hopes_reg, path_hopes_next;
    logic [3:0] header_count_reg, header_count_next;
    hdr_phase_t header_phase_reg, header_phase_next;
    logic       keep_seen_reg, keep_seen_next;

    always_comb
    begin
        logic       do_value;
        logic [3:0] hc_v;
        logic [7:0] b;

        b                 = word.data;
        do_value          = 1'b0;
        hc_v              = 4'd0;
        phase_next        = phase_reg;
        path_count_next   = path_count_reg;
        path_hopes_next   = path_hopes_reg;
        header_count_next = header_count_reg;
        header_phase_next = header_phase_reg;
        keep_seen_next    = keep_seen_reg;

        if (word.step)
        begin
            case (phase_reg)
                PH_METHOD:
                begin
                    if (b == CH_SP)
                        phase_next = PH_PATH;
                end
                PH_PATH:
                begin
                    if (b inside {CH_SP, CH_CR})
                        phase_next = PH_HDR;
                    else
                    begin
                        if (path_count_reg != 4'd0 || b != CH_SLASH)
                            path_hopes_next[HOPE_ROOT] = 1'b0;
                        if (path_count_reg < STATS_LEN && b != stats_char(path_count_reg))
                            path_hopes_next[HOPE_STATS] = 1'b0;
                        if (path_count_reg < EVENTS_LEN && b != events_char(path_count_reg))
                            path_hopes_next[HOPE_EVENTS] = 1'b0;
                        if (path_count_reg != COUNT_MAX)
                            path_count_next = path_count_reg + 4'd1;
                    end
                end
                PH_HDR:
                begin
                    if (header_phase_reg == HP_NAME)
                    begin
                        if (header_count_reg == HNAME_LEN)
                        begin
                            // byte after the colon: header counts, value starts here
                            header_phase_next = HP_VALUE;
                            header_count_next = 4'd0;
                            do_value          = 1'b1;
                            hc_v              = 4'd0;
                        end
                        else if (b == hname_char(header_count_reg))
                            header_count_next = header_count_reg + 4'd1;
                        else if (b == hname_char(4'd0))
                            header_count_next = 4'd1;
                        else
                            header_count_next = 4'd0;
                    end
                    else if (header_phase_reg == HP_VALUE)
                    begin
                        do_value = 1'b1;
                        hc_v     = header_count_reg;
                    end

                    if (do_value)
                    begin
                        if (hc_v == 4'd0 && b == CH_SP)
                            header_count_next = hc_v;
                        else if (hc_v < HVAL_LEN && b == hval_char(hc_v))
                        begin
                            header_count_next = hc_v + 4'd1;
                            if (hc_v == HVAL_LEN - 4'd1)
                            begin
                                keep_seen_next    = 1'b1;
                                header_phase_next = HP_DONE;
                            end
                        end
                        else
                            header_phase_next = HP_DONE;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (phase_next == PH_METHOD)
            result.route = ROUTE_ROOT;
        else if (path_count_next == 4'd1 && path_hopes_next[HOPE_ROOT])
            result.route = ROUTE_ROOT;
        else if (path_count_next >= STATS_LEN && path_hopes_next[HOPE_STATS])
            result.route = ROUTE_STATS;
        else if (path_count_next >= EVENTS_LEN && path_hopes_next[HOPE_EVENTS])
            result.route = ROUTE_EVENTS;
        else
            result.route = ROUTE_NOTFOUND;
        result.persist = keep_seen_next || (result.route == ROUTE_EVENTS);

        // end of request: back to the start state
        if (word.step && word.last)
        begin
            phase_next        = PH_METHOD;
            path_count_next   = 4'd0;
            path_hopes_next   = 3'b111;
            header_count_next = 4'd0;
            header_phase_next = HP_NAME;
            keep_seen_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_METHOD;
            path_count_reg   <= 4'd0;
            path_hopes_reg   <= 3'b111;
            header_count_reg <= 4'd0;
            header_phase_reg <= HP_NAME;
            keep_seen_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            path_count_reg   <= path_count_next;
            path_hopes_reg   <= path_hopes_next;
            header_count_reg <= header_count_next;
            header_phase_reg <= header_phase_next;
            keep_seen_reg    <= keep_seen_next;
        end
    end

    `HRR_ASSERT(a_restart_after_last, clk, rst_n,
        word.step && word.last |=> phase_reg == PH_METHOD && header_count_reg == 4'd0 &&
        !keep_seen_reg && path_hopes_reg == 3'b111)
    `HRR_ASSERT(a_keep_only_when_done, clk, rst_n,
        keep_seen_reg |-> header_phase_reg == HP_DONE && phase_reg == PH_HDR)
    `HRR_ASSERT_ALWAYS(a_name_count_range, clk,
        header_phase_reg == HP_NAME |-> header_count_reg <= HNAME_LEN)

endmodule

>>> design/http_request_router.sv
`timescale 1ns / 1ps
`include "http_request_router_assert.svh"

// HTTP request router.
// Input channel: one request byte per word on byte_in, with last marking the
// final byte; a word moves when in_valid is high and in_stall is low.
// Output channel: one word per request (route, persist), shown on
// out_valid and held while out_stall is high.
// Route codes: 0 root, 1 stats, 2 event stream (persist forced), 3 not found.
// The last byte of a request passes the input register, then the result
// register, before out_valid rises; a stalled result ahead of it can hold it
// in the input register.
// Throughput: one byte per cycle while in_stall is low; the per-byte match sits
// between the input register and the parse state, so bytes flow back to back.
// A stalled result blocks only the next last byte; other bytes keep flowing,
// and in_stall rises only when a held byte cannot advance.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the start of a request.

module http_request_router
    import hrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] byte_in,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] route,
    output logic       persist
);

    logic        in_vld_reg, in_vld_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic        out_vld_reg, out_vld_next;
    hrr_result_t res_reg;
    hrr_result_t res_comb;
    hrr_word_t   word;
    logic        adv;
    logic        take;

    assign adv      = in_vld_reg && (!last_reg || !out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !adv;
    assign take     = in_valid && !in_stall;

    assign word.step = adv;
    assign word.last = last_reg;
    assign word.data = byte_reg;

    hrr_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .word   (word),
        .result (res_comb)
    );

    always_comb
    begin
        if (take)
            in_vld_next = 1'b1;
        else if (adv)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;

        if (adv && last_reg)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= byte_in;
            last_reg <= last;
        end
        if (adv && last_reg)
            res_reg <= res_comb;
    end

    assign out_valid = out_vld_reg;
    assign route     = res_reg.route;
    assign persist   = res_reg.persist;

    `HRR_ASSERT(a_events_keep, clk, rst_n,
        out_vld_reg && res_reg.route == ROUTE_EVENTS |-> res_reg.persist)
    `HRR_ASSERT(a_result_from_last, clk, rst_n,
        out_vld_reg && !$past(out_vld_reg) |-> $past(in_vld_reg && last_reg))
    `HRR_ASSERT_ALWAYS(a_stall_holds_word, clk,
        in_stall |-> in_vld_reg && last_reg && out_vld_reg)

endmodule

>>> bench/http_request_router_test.sv
`timescale 1ns / 1ps

module http_request_router_test
    import hrr_pkg::*;
();

    typedef logic [7:0] octet_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] byte_in = 8'h00;
    logic       last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] route;
    logic       persist;

    http_request_router uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .byte_in    (byte_in),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .route      (route),
        .persist    (persist)
    );

    string stats_path = "/api/stats";
    string events_path = "/events";
    string conn_name = "Connection:";
    string ka_value = "keep-alive";

    // parser state mirrored by the predictor
    phase_t     parse_st;
    logic [3:0] path_len;
    logic [2:0] path_cand;
    hdr_phase_t hdr_st;
    logic [3:0] hdr_idx;
    logic       keep_flag;

    hrr_result_t pending_routes[$];
    octet_t      req_buf[$];

    int send_gap_pct = 0;
    int recv_gap_pct = 0;
    int fail_count = 0;
    int byte_count = 0;
    int req_count = 0;
    int result_count = 0;
    int route_hits[4] = '{0, 0, 0, 0};
    int keep_hits = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic clear_parse_state();
        parse_st  = PH_METHOD;
        path_len  = 4'd0;
        path_cand = 3'b111;
        hdr_st    = HP_NAME;
        hdr_idx   = 4'd0;
        keep_flag = 1'b0;
    endtask

    task automatic path_step(input octet_t b);
        if (path_len != 4'd0 || b != CH_SLASH)
            path_cand[HOPE_ROOT] = 1'b0;
        if (path_len < STATS_LEN && b != stats_path[path_len])
            path_cand[HOPE_STATS] = 1'b0;
        if (path_len < EVENTS_LEN && b != events_path[path_len])
            path_cand[HOPE_EVENTS] = 1'b0;
        if (path_len < COUNT_MAX)
            path_len = path_len + 4'd1;
    endtask

    task automatic header_step(input octet_t b);
        if (hdr_st == HP_NAME && hdr_idx != HNAME_LEN)
        begin
            if (b == conn_name[hdr_idx])
                hdr_idx = hdr_idx + 4'd1;
            else
                hdr_idx = (b == conn_name[0]) ? 4'd1 : 4'd0;
        end
        else
        begin
            // name matched and a byte follows the colon
            if (hdr_st == HP_NAME)
            begin
                hdr_st  = HP_VALUE;
                hdr_idx = 4'd0;
            end
            if (hdr_st == HP_VALUE && !(hdr_idx == 4'd0 && b == CH_SP))
            begin
                if (hdr_idx < HVAL_LEN && b == ka_value[hdr_idx])
                begin
                    hdr_idx = hdr_idx + 4'd1;
                    if (hdr_idx == HVAL_LEN)
                    begin
                        keep_flag = 1'b1;
                        hdr_st    = HP_DONE;
                    end
                end
                else
                    hdr_st = HP_DONE;
            end
        end
    endtask

    task automatic route_predict(input octet_t b, input logic is_last);
        hrr_result_t res;
        case (parse_st)
            PH_METHOD:
                if (b == CH_SP)
                    parse_st = PH_PATH;
            PH_PATH:
                if (b == CH_SP || b == CH_CR)
                    parse_st = PH_HDR;
                else
                    path_step(b);
            default:
                header_step(b);
        endcase
        if (is_last)
        begin
            if (parse_st == PH_METHOD)
                res.route = ROUTE_ROOT;
            else if (path_len == 4'd1 && path_cand[HOPE_ROOT])
                res.route = ROUTE_ROOT;
            else if (path_len >= STATS_LEN && path_cand[HOPE_STATS])
                res.route = ROUTE_STATS;
            else if (path_len >= EVENTS_LEN && path_cand[HOPE_EVENTS])
                res.route = ROUTE_EVENTS;
            else
                res.route = ROUTE_NOTFOUND;
            res.persist = keep_flag | (res.route == ROUTE_EVENTS);
            pending_routes.push_back(res);
            clear_parse_state();
        end
    endtask

    // one word on the input channel
    task automatic send_byte(input octet_t b, input logic is_last);
        in_valid <= 1'b1;
        byte_in  <= b;
        last     <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        route_predict(b, is_last);
        byte_count++;
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            byte_in  <= octet_t'($urandom);
            last     <= 1'($urandom_range(1));
            @(posedge clk);
        end
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            req_buf.push_back(s[i]);
    endtask

    task automatic send_request();
        for (int i = 0; i < req_buf.size(); i++)
            send_byte(req_buf[i], i == req_buf.size() - 1);
        req_buf.delete();
        req_count++;
    endtask

    task automatic send_text(input string s);
        add_text(s);
        send_request();
    endtask

    // result checker
    initial
    begin
        hrr_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_routes.size() == 0)
                begin
                    $error("unexpected result: route %0d persist %0d", route, persist);
                    fail_count++;
                end
                else
                begin
                    want = pending_routes.pop_front();
                    result_count++;
                    route_hits[want.route]++;
                    if (want.persist)
                        keep_hits++;
                    if (route !== want.route)
                    begin
                        $error("route: expected %0d, actual %0d", want.route, route);
                        fail_count++;
                    end
                    if (persist !== want.persist)
                    begin
                        $error("persist: expected %0d, actual %0d",
                               want.persist, persist);
                        fail_count++;
                    end
                end
            end
            out_stall <= (recv_gap_pct > 0) && ($urandom_range(99) < recv_gap_pct);
        end
    end

    task automatic test_no_space();
        send_text("GET");
        req_buf.push_back(8'h00);
        send_request();
        req_buf.push_back(8'hFF);
        send_request();
    endtask

    task automatic test_empty_path();
        send_text(" ");
        send_text("GET  x");
    endtask

    task automatic test_path_routes();
        send_text(" /");
        send_text("GET /api/stats");
        send_text("GET /events");
        send_text(" /x");
        send_text(" /ev");
        send_text(" /api/statsZZZZZZZZZ");
        send_text(" /\015");
    endtask

    task automatic test_conn_header();
        send_text(" / Connection: keep-alive");
        send_text(" /\015Connection:keep-alive\015\012");
        send_text(" /api/stats CConnection:   keep-alive ");
    endtask

    task automatic test_colon_last();
        send_text(" / Connection:");
    endtask

    task automatic test_first_header();
        send_text(" / Connection: close\015\012Connection: keep-alive");
    endtask

    task automatic test_events_forced();
        send_text(" /events Connection: close");
    endtask

    task automatic add_random_path();
        string p;
        int    n;
        case ($urandom_range(10))
            0: add_text("/");
            1: add_text(stats_path);
            2: add_text({stats_path, "/x"});
            3: add_text(events_path);
            4: add_text({events_path, "?id=7"});
            5: add_text("/api/stat");
            6: add_text("/event");
            7: ;
            8:
            begin
                n = $urandom_range(1, 14);
                repeat (n)
                    req_buf.push_back(octet_t'($urandom_range(33, 126)));
            end
            9:
            begin
                p = ($urandom_range(1)) ? stats_path : events_path;
                p[$urandom_range(p.len() - 1)] = octet_t'($urandom_range(33, 126));
                add_text(p);
            end
            default: add_text({stats_path, "ABCDEFGHIJ"});
        endcase
    endtask

    task automatic add_random_header();
        case ($urandom_range(9))
            0: add_text("Connection: keep-alive");
            1: add_text("Connection:keep-alive");
            2: add_text("Connection:    keep-alive");
            3: add_text("Connection: close");
            4: add_text("Connection: keep-alivX");
            5: add_text("Connection:");
            6: add_text("Connectio: keep-alive");
            7: add_text("CConnection: keep-alive");
            8: add_text("connection: keep-alive");
            default: add_text("Host: h");
        endcase
    endtask

    task automatic build_random_request();
        int n;
        int cut;
        int term;
        if ($urandom_range(99) < 10)
        begin
            n = $urandom_range(1, 20);
            repeat (n)
                req_buf.push_back(octet_t'($urandom));
        end
        else
        begin
            case ($urandom_range(5))
                0: add_text("GET");
                1: add_text("POST");
                2: add_text("DELETE");
                3: add_text("HEAD");
                4: add_text("OPTIONS");
                default: ;
            endcase
            if ($urandom_range(99) < 95)
                req_buf.push_back(CH_SP);
            add_random_path();
            term = $urandom_range(99);
            if (term < 85)
            begin
                req_buf.push_back((term < 60) ? CH_SP : CH_CR);
                if ($urandom_range(3) == 0)
                    add_text("HTTP/1.1\015\012");
                n = $urandom_range(3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        add_text("\015\012");
                    add_random_header();
                end
                if ($urandom_range(1))
                    add_text("\015\012");
            end
        end
        if (req_buf.size() > 1 && $urandom_range(99) < 15)
        begin
            cut = $urandom_range(1, req_buf.size() - 1);
            while (req_buf.size() > cut)
                void'(req_buf.pop_back());
        end
        if (req_buf.size() == 0)
            req_buf.push_back(octet_t'($urandom));
    endtask

    task automatic test_random(input int s_pct, input int r_pct, input int min_bytes,
                               input int min_reqs);
        int b0;
        int r0;
        send_gap_pct = s_pct;
        recv_gap_pct = r_pct;
        b0 = byte_count;
        r0 = req_count;
        while (byte_count - b0 < min_bytes || req_count - r0 < min_reqs)
        begin
            build_random_request();
            send_request();
        end
    endtask

    task automatic finish_run();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (pending_routes.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10)
            @(posedge clk);
        if (pending_routes.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_routes.size());
            fail_count++;
        end
        $display("%0d requests in %0d bytes, %0d results checked", req_count, byte_count,
                 result_count);
        $display("routes root/stats/events/notfound: %0d/%0d/%0d/%0d, persist set: %0d",
                 route_hits[ROUTE_ROOT], route_hits[ROUTE_STATS],
                 route_hits[ROUTE_EVENTS], route_hits[ROUTE_NOTFOUND], keep_hits);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    endtask

    initial
    begin
        clear_parse_state();
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gap_pct = 26;
        recv_gap_pct = 58;
        test_no_space();
        test_empty_path();
        test_path_routes();
        test_conn_header();
        test_colon_last();
        test_first_header();
        test_events_forced();
        test_random(26, 58, 110, 3);
        test_random(58, 26, 110, 3);
        test_random(0, 0, 110, 3);
        finish_run();
    end

endmodule
